>>> rtl/core/irctok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irctok_pkg;

    localparam int MAX_ARGS = 16;
    localparam int ARGC_W   = 5;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_AT    = 8'h40;

    typedef enum logic [2:0] {
        KIND_NICK = 3'd0,
        KIND_USER = 3'd1,
        KIND_HOST = 3'd2,
        KIND_CMD  = 3'd3,
        KIND_ARG  = 3'd4,
        KIND_END  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_NICK     = 3'd1,
        PH_USER     = 3'd2,
        PH_HOST     = 3'd3,
        PH_CMD      = 3'd4,
        PH_ARGSTART = 3'd5,
        PH_ARG      = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        kind_t             field_kind;
        logic [3:0]        arg_number;
        logic              is_trailing;
        logic              line_done;
        logic [ARGC_W-1:0] arg_total;
        logic              line_status;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/core/irctok_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface irctok_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/irctok_tok_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface irctok_tok_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   out_byte;
    logic [2:0]                   field_kind;
    logic [3:0]                   arg_number;
    logic                         is_trailing;
    logic                         line_done;
    logic [irctok_pkg::ARGC_W-1:0] arg_total;
    logic                         line_status;
    logic                         last;

    modport source (output valid, output out_byte, output field_kind, output arg_number,
                    output is_trailing, output line_done, output arg_total,
                    output line_status, output last, input ready);
    modport sink (input valid, input out_byte, input field_kind, input arg_number,
                  input is_trailing, input line_done, input arg_total,
                  input line_status, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/irctok_front.sv
`timescale 1ns / 1ps
`default_nettype none

module irctok_front (
    input  wire                     clk,
    input  wire                     rst_n,
    irctok_byte_if.sink             bytes,
    input  irctok_pkg::q_status_t   q_status,
    output logic                    push,
    output irctok_pkg::work_t       push_data
);

    typedef struct packed {
        irctok_pkg::phase_t              phase;
        logic [irctok_pkg::ARGC_W-1:0]   argc;
        logic                            azb;
        logic                            trail;
    } tok_state_t;

    typedef struct packed {
        tok_state_t          st;
        logic                emit;
        irctok_pkg::result_t r;
    } cont_t;

    function automatic cont_t content_eval(input tok_state_t s, input logic [7:0] b);
        cont_t                           c;
        irctok_pkg::phase_t              ph;
        logic                            absorb;
        logic [irctok_pkg::ARGC_W-1:0]   am1;
        c          = '0;
        c.st       = s;
        c.r.out_byte = b;
        ph         = s.phase;
        absorb     = s.trail || (s.argc >= irctok_pkg::ARGC_W'(irctok_pkg::MAX_ARGS));
        am1        = s.argc - irctok_pkg::ARGC_W'(1);
        if (!s.azb)
        begin
            if (b == irctok_pkg::CHAR_NUL)
            begin
                c.st.azb = 1'b1;
            end
            else if (ph == irctok_pkg::PH_START && b == irctok_pkg::CHAR_COLON)
            begin
                c.st.phase = irctok_pkg::PH_NICK;
            end
            else
            begin
                if (ph == irctok_pkg::PH_START)
                begin
                    ph         = irctok_pkg::PH_CMD;
                    c.st.phase = irctok_pkg::PH_CMD;
                end
                case (ph)
                    irctok_pkg::PH_NICK:
                    begin
                        if (b == irctok_pkg::CHAR_SPACE)
                        begin
                            c.st.phase = irctok_pkg::PH_CMD;
                        end
                        else if (b == irctok_pkg::CHAR_BANG)
                        begin
                            c.st.phase = irctok_pkg::PH_USER;
                        end
                        else
                        begin
                            c.emit         = 1'b1;
                            c.r.field_kind = irctok_pkg::KIND_NICK;
                        end
                    end
                    irctok_pkg::PH_USER:
                    begin
                        if (b == irctok_pkg::CHAR_SPACE)
                        begin
                            c.st.phase = irctok_pkg::PH_CMD;
                        end
                        else if (b == irctok_pkg::CHAR_AT)
                        begin
                            c.st.phase = irctok_pkg::PH_HOST;
                        end
                        else
                        begin
                            c.emit         = 1'b1;
                            c.r.field_kind = irctok_pkg::KIND_USER;
                        end
                    end
                    irctok_pkg::PH_HOST:
                    begin
                        if (b == irctok_pkg::CHAR_SPACE)
                        begin
                            c.st.phase = irctok_pkg::PH_CMD;
                        end
                        else
                        begin
                            c.emit         = 1'b1;
                            c.r.field_kind = irctok_pkg::KIND_HOST;
                        end
                    end
                    irctok_pkg::PH_CMD:
                    begin
                        if (b == irctok_pkg::CHAR_SPACE)
                        begin
                            c.st.argc  = irctok_pkg::ARGC_W'(1);
                            c.st.phase = irctok_pkg::PH_ARGSTART;
                        end
                        else
                        begin
                            c.emit         = 1'b1;
                            c.r.field_kind = irctok_pkg::KIND_CMD;
                        end
                    end
                    default:
                    begin
                        if (ph == irctok_pkg::PH_ARGSTART && b == irctok_pkg::CHAR_COLON)
                        begin
                            c.st.trail = 1'b1;
                            c.st.phase = irctok_pkg::PH_ARG;
                        end
                        else if (!absorb && b == irctok_pkg::CHAR_SPACE)
                        begin
                            c.st.argc  = s.argc + irctok_pkg::ARGC_W'(1);
                            c.st.phase = irctok_pkg::PH_ARGSTART;
                        end
                        else
                        begin
                            c.st.phase      = irctok_pkg::PH_ARG;
                            c.emit          = 1'b1;
                            c.r.field_kind  = irctok_pkg::KIND_ARG;
                            c.r.arg_number  = am1[3:0];
                            c.r.is_trailing = s.trail;
                        end
                    end
                endcase
            end
        end
        return c;
    endfunction

    function automatic tok_state_t st_line_rst();
        tok_state_t s;
        s       = '0;
        s.phase = irctok_pkg::PH_START;
        return s;
    endfunction

    tok_state_t          st_reg;
    tok_state_t          st_next;
    logic                cr_reg;
    logic                cr_next;

    tok_state_t          st_line;
    tok_state_t          s1;
    cont_t               c1;
    cont_t               c2;
    logic                use1;
    logic                e1;
    logic                eb;
    logic                is_cr;
    logic                is_end;
    logic                no_cmd;
    logic                accept;
    irctok_pkg::result_t rb;
    irctok_pkg::result_t r_end;

    assign bytes.ready = !q_status.full;
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        st_line       = '0;
        st_line.phase = irctok_pkg::PH_START;
        is_cr  = (bytes.in_byte == irctok_pkg::CHAR_CR);
        is_end = (bytes.in_byte == irctok_pkg::CHAR_LF) && cr_reg;
        use1   = cr_reg && (bytes.in_byte != irctok_pkg::CHAR_LF);
        c1     = content_eval(st_reg, irctok_pkg::CHAR_CR);
        s1     = use1 ? c1.st : st_reg;
        e1     = use1 && c1.emit;
        c2     = content_eval(s1, bytes.in_byte);
        no_cmd = (s1.phase == irctok_pkg::PH_NICK) || (s1.phase == irctok_pkg::PH_USER)
              || (s1.phase == irctok_pkg::PH_HOST);
    end

    // next state
    always_comb
    begin
        if (is_cr)
        begin
            st_next = s1;
            cr_next = 1'b1;
        end
        else if (is_end)
        begin
            st_next = st_line;
            cr_next = 1'b0;
        end
        else
        begin
            st_next = c2.st;
            cr_next = 1'b0;
        end
    end

    // outputs
    always_comb
    begin
        r_end             = '0;
        r_end.field_kind  = irctok_pkg::KIND_END;
        r_end.line_done   = 1'b1;
        r_end.arg_total   = no_cmd ? '0 : s1.argc;
        r_end.line_status = no_cmd;
        rb = is_end ? r_end : c2.r;
        eb = is_end || (!is_cr && c2.emit);
        rb.last = 1'b1;
        push_data.two     = e1 && eb;
        push_data.r1      = rb;
        push_data.r0      = e1 ? c1.r : rb;
        push_data.r0.last = !(e1 && eb);
        push = accept && (e1 || eb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= st_line_rst();
            cr_reg <= 1'b0;
        end
        else if (accept)
        begin
            st_reg <= st_next;
            cr_reg <= cr_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/irctok_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module irctok_queue (
    input  wire                     clk,
    input  wire                     rst_n,
    input  logic                    push,
    input  irctok_pkg::work_t       push_data,
    input  logic                    pop,
    output irctok_pkg::work_t       head,
    output irctok_pkg::q_status_t   q_status
);

    irctok_pkg::work_t               mem_reg [irctok_pkg::QDEPTH];
    logic [irctok_pkg::QPTR_W-1:0]   wr_reg;
    logic [irctok_pkg::QPTR_W-1:0]   wr_next;
    logic [irctok_pkg::QPTR_W-1:0]   rd_reg;
    logic [irctok_pkg::QPTR_W-1:0]   rd_next;
    logic [irctok_pkg::QPTR_W:0]     cnt_reg;
    logic [irctok_pkg::QPTR_W:0]     cnt_next;

    assign q_status.full  = (cnt_reg == (irctok_pkg::QPTR_W+1)'(irctok_pkg::QDEPTH));
    assign q_status.empty = (cnt_reg == '0);
    assign head           = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (irctok_pkg::QPTR_W+1)'(push) - (irctok_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/irctok_back.sv
`timescale 1ns / 1ps
`default_nettype none

module irctok_back (
    input  wire                     clk,
    input  wire                     rst_n,
    input  irctok_pkg::work_t       head,
    input  irctok_pkg::q_status_t   q_status,
    output logic                    pop,
    irctok_tok_if.source            tokens
);

    irctok_pkg::result_t out_reg;
    irctok_pkg::result_t out_next;
    irctok_pkg::result_t pend_reg;
    irctok_pkg::result_t pend_next;
    logic                ov_reg;
    logic                ov_next;
    logic                pv_reg;
    logic                pv_next;
    logic                free;

    always_comb
    begin
        free      = !ov_reg || tokens.ready;
        out_next  = out_reg;
        pend_next = pend_reg;
        ov_next   = ov_reg;
        pv_next   = pv_reg;
        pop       = 1'b0;
        if (free)
        begin
            if (pv_reg)
            begin
                // send second word of the pair
                out_next = pend_reg;
                ov_next  = 1'b1;
                pv_next  = 1'b0;
            end
            else if (!q_status.empty)
            begin
                out_next  = head.r0;
                pend_next = head.r1;
                ov_next   = 1'b1;
                pv_next   = head.two;
                pop       = 1'b1;
            end
            else
            begin
                ov_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            pv_reg <= pv_next;
        end
    end

    assign tokens.valid       = ov_reg;
    assign tokens.out_byte    = out_reg.out_byte;
    assign tokens.field_kind  = out_reg.field_kind;
    assign tokens.arg_number  = out_reg.arg_number;
    assign tokens.is_trailing = out_reg.is_trailing;
    assign tokens.line_done   = out_reg.line_done;
    assign tokens.arg_total   = out_reg.arg_total;
    assign tokens.line_status = out_reg.line_status;
    assign tokens.last        = out_reg.last;

endmodule

`default_nettype wire

>>> rtl/core/irc_line_tokenizer.sv
// Path: a byte's words are queued, then loaded into the output register when it is free.
// Throughput: one byte per cycle while the queue is not full; a byte yielding two
// words (held CR) takes one entry of the 4-entry queue between tokenizer and output.
// Reset: rst_n asynchronous, active low; clears the line state, held CR, queue and
// output valid. Payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module irc_line_tokenizer (
    input  wire             clk,
    input  wire             rst_n,
    irctok_byte_if.sink     bytes,
    irctok_tok_if.source    tokens
);

    irctok_pkg::q_status_t q_status;
    irctok_pkg::work_t     push_data;
    irctok_pkg::work_t     head;
    logic                  push;
    logic                  pop;

    irctok_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    irctok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    irctok_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .tokens   (tokens)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !pop)
        else $error("pop from empty queue");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.ready && !tokens.last) |=> tokens.valid)
        else $error("second word of pair missing");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && tokens.line_done) |->
            (tokens.last && tokens.out_byte == irctok_pkg::CHAR_NUL
             && tokens.field_kind == irctok_pkg::KIND_END))
        else $error("malformed line-end marker");

endmodule

`default_nettype wire
